// ===== rtl/complex_arith_unit_assert.svh =====
// ----------------------------------------------------------------------------
// complex_arith_unit_assert.svh
// assertion macros for the complex arithmetic unit
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITH_UNIT_ASSERT_SVH
`define COMPLEX_ARITH_UNIT_ASSERT_SVH

// implication checked on every clock edge outside reset
`define CAU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// condition checked on every clock edge outside reset
`define CAU_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

`endif

// ===== rtl/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// cau_pkg
// types, constants and step functions of the complex arithmetic unit
// ----------------------------------------------------------------------------
package cau_pkg;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef struct packed {
        op_t                op;
        logic signed [15:0] a_real;
        logic signed [15:0] a_imag;
        logic signed [15:0] b_real;
        logic signed [15:0] b_imag;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] real_out;
        logic signed [31:0] imag_out;
        logic               div_by_zero;
        logic               saturated;
    } out_beat_t;

    // dividend magnitude is at most 2^47, one quotient bit per stage
    localparam int DIV_STEPS = 48;

    typedef struct packed {
        logic                     neg;
        logic [31:0]              rem;
        logic [DIV_STEPS-1:0]     nq;   // dividend bits shift out, quotient bits in
    } div_lane_t;

    typedef struct packed {
        op_t                op;
        logic               dz;
        logic signed [33:0] res_re;
        logic signed [33:0] res_im;
        logic [31:0]        den;
        div_lane_t          re;
        div_lane_t          im;
    } stg_t;

    typedef struct packed {
        logic        sat;
        logic [31:0] val;
    } clip_t;

    // one restoring step: bring in the next dividend bit, subtract if it fits
    function automatic div_lane_t div_step(input div_lane_t l, input logic [31:0] den);
        logic [32:0] t;
        logic [32:0] d;
        logic        ge;
        div_lane_t   r;
        t = {l.rem, l.nq[DIV_STEPS-1]};
        d = {1'b0, den};
        ge = (t >= d);
        r.neg = l.neg;
        r.rem = ge ? 32'(t - d) : t[31:0];
        r.nq = {l.nq[DIV_STEPS-2:0], ge};
        return r;
    endfunction

    function automatic clip_t clip_res(input logic signed [33:0] v);
        clip_t c;
        if (v > 34'sh0_7FFF_FFFF) begin
            c.sat = 1'b1;
            c.val = 32'h7FFF_FFFF;
        end else if (v < -34'sh0_8000_0000) begin
            c.sat = 1'b1;
            c.val = 32'h8000_0000;
        end else begin
            c.sat = 1'b0;
            c.val = v[31:0];
        end
        return c;
    endfunction

    // quotient magnitude with sign applied, clipped to 32 bits
    function automatic clip_t clip_quo(input logic [DIV_STEPS-1:0] mag, input logic neg);
        clip_t c;
        if (!neg) begin
            c.sat = |mag[DIV_STEPS-1:31];
            c.val = c.sat ? 32'h7FFF_FFFF : mag[31:0];
        end else begin
            c.sat = (mag > DIV_STEPS'(33'h0_8000_0000));
            c.val = c.sat ? 32'h8000_0000 : 32'(~mag[31:0] + 32'd1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/complex_arith_unit.sv =====
// pipeline: input beat to result beat passes 3 front stages,
//   48 restoring divider stages at one quotient bit each, and the output register
// throughput: one beat per cycle; the whole pipeline stalls as one when the
//   output register is full and m_ready is low
// reset: synchronous, active low aresetn clears all valid bits
// ----------------------------------------------------------------------------
// complex_arith_unit
// pipelined complex add, subtract, multiply and divide, Q8.8 in, Q16.16 out
// ----------------------------------------------------------------------------
`include "complex_arith_unit_assert.svh"

module complex_arith_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  cau_pkg::in_beat_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output cau_pkg::out_beat_t m_data
);

    localparam int NS = cau_pkg::DIV_STEPS;

    // single enable for every stage: advance unless the result is stuck
    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // ---- stage a: register the input beat
    logic              a_valid_reg;
    cau_pkg::in_beat_t a_beat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= s_valid;
        end
        if (adv) begin
            a_beat_reg <= s_data;
        end
    end

    // ---- stage b: the six 16x16 products, plus add/subtract results
    logic               b_valid_reg;
    cau_pkg::op_t       b_op_reg;
    logic signed [31:0] p_rr_reg, p_ii_reg, p_ir_reg, p_ri_reg, p_bb_reg, p_dd_reg;
    logic signed [33:0] b_re_reg, b_im_reg;
    logic signed [33:0] b_re_next, b_im_next;

    // add/subtract widened to 17 bits, then scaled by 256 into Q16.16
    always_comb begin
        logic signed [16:0] sr;
        logic signed [16:0] si;
        if (a_beat_reg.op == cau_pkg::OP_SUB) begin
            sr = 17'(a_beat_reg.a_real) - 17'(a_beat_reg.b_real);
            si = 17'(a_beat_reg.a_imag) - 17'(a_beat_reg.b_imag);
        end else begin
            sr = 17'(a_beat_reg.a_real) + 17'(a_beat_reg.b_real);
            si = 17'(a_beat_reg.a_imag) + 17'(a_beat_reg.b_imag);
        end
        b_re_next = {{9{sr[16]}}, sr, 8'd0};
        b_im_next = {{9{si[16]}}, si, 8'd0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (adv) begin
            b_valid_reg <= a_valid_reg;
        end
        if (adv) begin
            b_op_reg <= a_beat_reg.op;
            p_rr_reg <= a_beat_reg.a_real * a_beat_reg.b_real;
            p_ii_reg <= a_beat_reg.a_imag * a_beat_reg.b_imag;
            p_ir_reg <= a_beat_reg.a_imag * a_beat_reg.b_real;
            p_ri_reg <= a_beat_reg.a_real * a_beat_reg.b_imag;
            p_bb_reg <= a_beat_reg.b_real * a_beat_reg.b_real;
            p_dd_reg <= a_beat_reg.b_imag * a_beat_reg.b_imag;
            b_re_reg <= b_re_next;
            b_im_reg <= b_im_next;
        end
    end

    // ---- stage c: sums of products, dividend setup for the divider
    cau_pkg::stg_t c_stg_next;

    always_comb begin
        logic signed [32:0] nre;
        logic signed [32:0] nim;
        logic [31:0]        den;
        logic [31:0]        mre;
        logic [31:0]        mim;
        nre = 33'(p_rr_reg) + 33'(p_ii_reg);
        nim = 33'(p_ir_reg) - 33'(p_ri_reg);
        den = 32'(p_bb_reg) + 32'(p_dd_reg);
        mre = nre[32] ? 32'(-nre) : nre[31:0];
        mim = nim[32] ? 32'(-nim) : nim[31:0];

        c_stg_next.op  = b_op_reg;
        c_stg_next.den = den;
        c_stg_next.dz  = (den == 32'd0);
        // multiply is exact, add/subtract passes through
        if (b_op_reg == cau_pkg::OP_MUL) begin
            c_stg_next.res_re = 34'(p_rr_reg) - 34'(p_ii_reg);
            c_stg_next.res_im = 34'(p_ri_reg) + 34'(p_ir_reg);
        end else begin
            c_stg_next.res_re = b_re_reg;
            c_stg_next.res_im = b_im_reg;
        end
        // numerator magnitude times 65536, denominator is never negative
        c_stg_next.re.neg = nre[32];
        c_stg_next.re.rem = 32'd0;
        c_stg_next.re.nq  = {mre, 16'd0};
        c_stg_next.im.neg = nim[32];
        c_stg_next.im.rem = 32'd0;
        c_stg_next.im.nq  = {mim, 16'd0};
    end

    // ---- divider stages: stg 0 is stage c, stg k holds k quotient bits
    logic          vld_reg [0:NS];
    cau_pkg::stg_t stg_reg [0:NS];
    cau_pkg::stg_t stg_next [1:NS];

    // each stage carries its beat along and adds one quotient bit per lane
    always_comb begin
        for (int k = 1; k <= NS; k++) begin
            stg_next[k]    = stg_reg[k-1];
            stg_next[k].re = cau_pkg::div_step(stg_reg[k-1].re, stg_reg[k-1].den);
            stg_next[k].im = cau_pkg::div_step(stg_reg[k-1].im, stg_reg[k-1].den);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= NS; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            vld_reg[0] <= b_valid_reg;
            for (int k = 1; k <= NS; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
        if (adv) begin
            stg_reg[0] <= c_stg_next;
            for (int k = 1; k <= NS; k++) begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

    // ---- output stage: select, saturate, zero-divisor override
    logic               m_valid_reg;
    cau_pkg::out_beat_t m_data_reg;
    cau_pkg::out_beat_t m_data_next;

    always_comb begin
        cau_pkg::clip_t cr;
        cau_pkg::clip_t ci;
        if (stg_reg[NS].op == cau_pkg::OP_DIV) begin
            cr = cau_pkg::clip_quo(stg_reg[NS].re.nq, stg_reg[NS].re.neg);
            ci = cau_pkg::clip_quo(stg_reg[NS].im.nq, stg_reg[NS].im.neg);
        end else begin
            cr = cau_pkg::clip_res(stg_reg[NS].res_re);
            ci = cau_pkg::clip_res(stg_reg[NS].res_im);
        end
        if (stg_reg[NS].op == cau_pkg::OP_DIV && stg_reg[NS].dz) begin
            // zero divisor: zero result, no saturation
            m_data_next.real_out    = '0;
            m_data_next.imag_out    = '0;
            m_data_next.div_by_zero = 1'b1;
            m_data_next.saturated   = 1'b0;
        end else begin
            m_data_next.real_out    = cr.val;
            m_data_next.imag_out    = ci.val;
            m_data_next.div_by_zero = 1'b0;
            m_data_next.saturated   = cr.sat | ci.sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= vld_reg[NS];
        end
        if (adv) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ---- assertions
    `CAU_ASSERT_ALWAYS(a_ready_follows_output, s_ready == (!m_valid || m_ready), "s_ready must track output register")
    `CAU_ASSERT_IMP(a_dz_zero_result, m_valid && m_data.div_by_zero, m_data.real_out == 32'sd0 && m_data.imag_out == 32'sd0 && !m_data.saturated, "zero divisor result not clean")
    `CAU_ASSERT_IMP(a_sat_at_bound, m_valid && m_data.saturated, m_data.real_out == 32'h7FFF_FFFF || m_data.real_out == 32'h8000_0000 || m_data.imag_out == 32'h7FFF_FFFF || m_data.imag_out == 32'h8000_0000, "saturated flag without clipped part")

endmodule
